/* rtl/mljb_pkg.sv */
// ----------------------------------------------------------------------------
// mljb_pkg
// Shared types, status codes and defaults of the multi-lane join buffer.
// ----------------------------------------------------------------------------
package mljb_pkg;

  localparam int LANE_W = 4;
  localparam int TAG_W  = 32;
  localparam int HDL_W  = 32;
  localparam int CNT_W  = 5;

  localparam int LANES_DEF          = 4;
  localparam int SLOTS_PER_LANE_DEF = 16;
  localparam int AGE_WINDOW_DEF     = 10;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_DUP     = 3'd1,
    ST_BADLANE = 3'd2,
    ST_FULL    = 3'd3,
    ST_JOINED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOOK,
    B_JREQ,
    B_JCHK,
    B_JRD,
    B_JOUT,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [TAG_W-1:0]  tag;
    logic [HDL_W-1:0]  handle;
    logic              bad_lane;
  } cmd_t;

endpackage

/* rtl/mljb_if.sv */
// ----------------------------------------------------------------------------
// mljb_if
// Word channels of the join buffer: the add request and the result.
// ----------------------------------------------------------------------------
interface mljb_req_if
  import mljb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] lane;
  logic [TAG_W-1:0]  tag_value;
  logic [HDL_W-1:0]  data_handle;

  modport source (output valid, lane, tag_value, data_handle, input ready);
  modport sink (input valid, lane, tag_value, data_handle, output ready);
endinterface

interface mljb_rsp_if
  import mljb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [LANE_W-1:0] out_lane;
  logic [TAG_W-1:0]  out_tag;
  logic [HDL_W-1:0]  out_handle;
  logic [CNT_W-1:0]  evicted_count;
  logic              last;

  modport source (output valid, status, out_lane, out_tag, out_handle, evicted_count, last,
                  input ready);
  modport sink (input valid, status, out_lane, out_tag, out_handle, evicted_count, last,
                output ready);
endinterface

/* rtl/mljb_front.sv */
// ----------------------------------------------------------------------------
// mljb_front
// Input stage: registers each request word and flags lanes out of range.
// ----------------------------------------------------------------------------
module mljb_front
  import mljb_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  mljb_req_if.sink        req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output cmd_t            cmd
);

  logic held;

  assign req.ready = !held || cmd_ready;
  assign cmd_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.ready) begin
      held <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      cmd.lane     <= req.lane;
      cmd.tag      <= req.tag_value;
      cmd.handle   <= req.data_handle;
      cmd.bad_lane <= {1'b0, req.lane} >= (LANE_W + 1)'(LANES);
    end
  end

endmodule

/* rtl/mljb_queue.sv */
// ----------------------------------------------------------------------------
// mljb_queue
// Short command queue between the input stage and the join engine.
// ----------------------------------------------------------------------------
module mljb_queue
  import mljb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign in_ready  = count != QCW'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* rtl/mljb_back.sv */
// ----------------------------------------------------------------------------
// mljb_back
// Join engine: checks a lane for duplicates, space and stale entries, stores
// the new entry, looks for the tag in every lane and emits the results.
// ----------------------------------------------------------------------------
module mljb_back
  import mljb_pkg::*;
#(
  parameter int LANES          = LANES_DEF,
  parameter int SLOTS_PER_LANE = SLOTS_PER_LANE_DEF,
  parameter int AGE_WINDOW     = AGE_WINDOW_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  mljb_rsp_if.source rsp
);

  localparam int NSLOTS = LANES * SLOTS_PER_LANE;
  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW     = $clog2(SLOTS_PER_LANE);
  localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int ROW_W  = SLOTS_PER_LANE * TAG_W;

  back_state_t state;
  back_state_t state_next;

  logic [ROW_W-1:0] tag_mem [LANES];
  logic [HDL_W-1:0] hdl_mem [NSLOTS];
  logic [ROW_W-1:0] row_q;
  logic [HDL_W-1:0] hdl_q;
  logic [NSLOTS-1:0] vbits;

  logic [LANE_W-1:0] cur_lane;
  logic [TAG_W-1:0]  cur_tag;
  logic [HDL_W-1:0]  cur_hdl;
  status_t           st;
  logic [CNT_W-1:0]  ev;
  logic [LW-1:0]     jl;
  logic [LW-1:0]     ol;
  logic [PW-1:0]     pos [LANES];

  logic [LW-1:0]             rd_addr;
  logic [LW-1:0]             sel_lane;
  logic [SW-1:0]             sel_base;
  logic [SLOTS_PER_LANE-1:0] lane_valid;
  logic [SLOTS_PER_LANE-1:0] match;
  logic [SLOTS_PER_LANE-1:0] evict;
  logic [PW-1:0]             match_pos;
  logic [PW-1:0]             free_pos;
  logic                      free_found;
  logic [CNT_W-1:0]          evict_cnt;
  logic [ROW_W-1:0]          tag_wrow;
  logic [TAG_W-1:0]          diff;
  logic [SW-1:0]             hrd_addr;

  logic             o_valid;
  status_t          o_status;
  logic [LANE_W-1:0] o_lane;
  logic [TAG_W-1:0] o_tag;
  logic [HDL_W-1:0] o_handle;
  logic [CNT_W-1:0] o_ev;
  logic             o_last;
  logic             can_load;

  assign can_load  = !o_valid || rsp.ready;
  assign cmd_ready = state == B_IDLE;

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.out_lane      = o_lane;
  assign rsp.out_tag       = o_tag;
  assign rsp.out_handle    = o_handle;
  assign rsp.evicted_count = o_ev;
  assign rsp.last          = o_last;

  always_comb begin
    case (state)
      B_IDLE:  rd_addr = cmd.lane[LW-1:0];
      B_JCHK:  rd_addr = jl + 1'b1;
      default: rd_addr = jl;
    endcase
  end

  always_ff @(posedge clk) begin
    row_q <= tag_mem[rd_addr];
    hdl_q <= hdl_mem[hrd_addr];
  end

  assign hrd_addr = SW'(ol * SLOTS_PER_LANE) + SW'(pos[ol]);
  assign sel_lane = (state == B_LOOK) ? cur_lane[LW-1:0] : jl;
  assign sel_base = SW'(sel_lane * SLOTS_PER_LANE);
  assign lane_valid = vbits[sel_base +: SLOTS_PER_LANE];

  always_comb begin
    match      = '0;
    evict      = '0;
    match_pos  = '0;
    free_pos   = '0;
    free_found = 1'b0;
    evict_cnt  = '0;
    diff       = '0;
    tag_wrow   = row_q;
    for (int p = 0; p < SLOTS_PER_LANE; p++) begin
      diff     = cur_tag - row_q[p*TAG_W +: TAG_W];
      match[p] = lane_valid[p] && (row_q[p*TAG_W +: TAG_W] == cur_tag);
      evict[p] = lane_valid[p] && !diff[TAG_W-1] && (diff > TAG_W'(AGE_WINDOW));
      if (match[p]) begin
        match_pos = PW'(p);
      end
      evict_cnt = evict_cnt + CNT_W'(evict[p]);
    end
    for (int p = SLOTS_PER_LANE - 1; p >= 0; p--) begin
      if (!lane_valid[p]) begin
        free_pos   = PW'(p);
        free_found = 1'b1;
      end
    end
    tag_wrow[free_pos*TAG_W +: TAG_W] = cur_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.bad_lane ? B_EMIT : B_LOOK;
        end
      end
      B_LOOK: begin
        state_next = ((|match) || !free_found) ? B_EMIT : B_JREQ;
      end
      B_JREQ: state_next = B_JCHK;
      B_JCHK: begin
        if (!(|match)) begin
          state_next = B_EMIT;
        end else if (jl == LW'(LANES - 1)) begin
          state_next = B_JRD;
        end
      end
      B_JRD: state_next = B_JOUT;
      B_JOUT: begin
        if (can_load) begin
          state_next = (ol == LW'(LANES - 1)) ? B_IDLE : B_JRD;
        end
      end
      B_EMIT: begin
        if (can_load) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (state == B_LOOK && !(|match) && free_found) begin
      for (int p = 0; p < SLOTS_PER_LANE; p++) begin
        if (evict[p]) begin
          vbits[sel_base + SW'(p)] <= 1'b0;
        end
      end
      vbits[sel_base + SW'(free_pos)] <= 1'b1;
    end else if (state == B_JRD) begin
      vbits[hrd_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOOK && !(|match) && free_found) begin
      tag_mem[cur_lane[LW-1:0]] <= tag_wrow;
      hdl_mem[sel_base + SW'(free_pos)] <= cur_hdl;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cur_lane <= cmd.lane;
          cur_tag  <= cmd.tag;
          cur_hdl  <= cmd.handle;
          st       <= ST_BADLANE;
          ev       <= '0;
          jl       <= '0;
          ol       <= '0;
        end
      end
      B_LOOK: begin
        if (|match) begin
          st <= ST_DUP;
        end else if (!free_found) begin
          st <= ST_FULL;
        end else begin
          ev <= evict_cnt;
        end
      end
      B_JCHK: begin
        if (!(|match)) begin
          st <= ST_PENDING;
        end else begin
          pos[jl] <= match_pos;
          jl      <= jl + 1'b1;
        end
      end
      B_JOUT: begin
        if (can_load) begin
          ol <= ol + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if ((state == B_EMIT || state == B_JOUT) && can_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT && can_load) begin
      o_status <= st;
      o_lane   <= cur_lane;
      o_tag    <= cur_tag;
      o_handle <= '0;
      o_ev     <= ev;
      o_last   <= 1'b1;
    end else if (state == B_JOUT && can_load) begin
      o_status <= ST_JOINED;
      o_lane   <= LANE_W'(ol);
      o_tag    <= cur_tag;
      o_handle <= hdl_q;
      o_ev     <= ev;
      o_last   <= ol == LW'(LANES - 1);
    end
  end

endmodule

/* rtl/multi_lane_join_buffer.sv */
// ----------------------------------------------------------------------------
// multi_lane_join_buffer
// Per-lane table of pending tagged entries that joins a tag once every lane
// holds it.
// ----------------------------------------------------------------------------
// The req channel carries one add word: lane, tag_value and data_handle. The
// rsp channel returns one status word per add, or, when the add completes a
// group, one joined word per lane in lane order with last set on the final
// one. Both channels use valid/ready; a word moves when both are high.
// A request passes an input register and a two-entry queue before the join
// engine, so further words are taken while the engine is busy. The engine
// goes from idle straight to output for a bad lane; through the lane lookup
// to output for a duplicate or a full lane; and for a pending add through the
// lookup, which stores the entry, and then searches the lanes in order until
// one lacks the tag. A join searches every lane, then for each lane reads the
// stored handle and loads the output register. The engine reads the tag
// memory one lane row at a time and works one add at a time: it takes no new
// command before it has finished with the last one.
// Synchronous reset clears all slot valid bits, the queue and the output
// valid flag; tag and handle storage keep their contents. When the
// receiver holds ready low, the output register holds its word and the
// engine stops at its next word until it is taken; the front fills the queue.
// ----------------------------------------------------------------------------
module multi_lane_join_buffer
  import mljb_pkg::*;
#(
  parameter int LANES          = LANES_DEF,
  parameter int SLOTS_PER_LANE = SLOTS_PER_LANE_DEF,
  parameter int AGE_WINDOW     = AGE_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mljb_req_if.sink   req,
  mljb_rsp_if.source rsp
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  mljb_front #(
    .LANES (LANES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  mljb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_cmd    (fr_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  mljb_back #(
    .LANES          (LANES),
    .SLOTS_PER_LANE (SLOTS_PER_LANE),
    .AGE_WINDOW     (AGE_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp       (rsp)
  );

endmodule
